// File: hdl/dtq_pkg.sv
// Shared types, constants and time helpers for the deadline timer queue.
package dtq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_FIRES_DEF  = 16;
    localparam int RESULT_LIMIT   = 16;
    localparam logic [19:0] USEC_MAX     = 20'd999999;
    localparam logic [20:0] USEC_PER_SEC = 21'd1000000;
    localparam logic [31:0] SEC_MAX      = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ARM    = 2'd1,
        OP_DISARM = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  timer_slot;
        logic [31:0] now_sec;
        logic [19:0] now_usec;
        logic [31:0] value_sec;
        logic [19:0] value_usec;
        logic [31:0] interval_sec;
        logic [19:0] interval_usec;
        logic        repeat_mode;
    } t_in_word;

    typedef struct packed {
        logic        fired;
        logic [3:0]  expired_slot;
        logic        last;
        logic        status;
        logic [31:0] old_remaining_sec;
        logic [19:0] old_remaining_usec;
        logic [31:0] old_interval_sec;
        logic [19:0] old_interval_usec;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIRE,
        ST_EMIT,
        ST_NOFIRE
    } t_exec_state;

    function automatic logic [19:0] clamp_us(input logic [19:0] v);
        clamp_us = (v > USEC_MAX) ? USEC_MAX : v;
    endfunction

    function automatic logic time_lt(input logic [31:0] as, input logic [19:0] aus,
                                     input logic [31:0] bs, input logic [19:0] bus);
        time_lt = (as < bs) || ((as == bs) && (aus < bus));
    endfunction

    // a + b with microsecond carry, saturating on seconds overflow
    function automatic logic [51:0] time_add(input logic [31:0] as, input logic [19:0] aus,
                                             input logic [31:0] bs, input logic [19:0] bus);
        logic [32:0] s;
        logic [20:0] us;
        begin
            us = {1'b0, aus} + {1'b0, bus};
            s  = {1'b0, as} + {1'b0, bs};
            if (us >= USEC_PER_SEC) begin
                us = us - USEC_PER_SEC;
                s  = s + 33'd1;
            end
            if (s[32]) begin
                time_add = {SEC_MAX, USEC_MAX};
            end else begin
                time_add = {s[31:0], us[19:0]};
            end
        end
    endfunction

endpackage

// File: hdl/dtq_front.sv
// Front end: input register, microsecond clamping and range check.
module dtq_front
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_word i_word,
    output logic     o_valid,
    output t_in_word o_word,
    output logic     o_bad_slot,
    input  logic     i_take
);
    logic     r_valid;
    t_in_word r_word;
    logic     r_bad;
    t_in_word n_word;

    always_comb begin
        n_word               = i_word;
        n_word.now_usec      = clamp_us(i_word.now_usec);
        n_word.value_usec    = clamp_us(i_word.value_usec);
        n_word.interval_usec = clamp_us(i_word.interval_usec);
        n_word.repeat_mode   = i_word.repeat_mode &
                               ((i_word.interval_sec != '0) || (i_word.interval_usec != '0));
    end

    assign o_full = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && !r_valid) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (i_push && !r_valid) begin
            r_word <= n_word;
            r_bad  <= ({3'b0, i_word.timer_slot} >= 7'(NUM_TIMERS));
        end
    end

    assign o_valid    = r_valid;
    assign o_word     = r_word;
    assign o_bad_slot = r_bad;
endmodule

// File: hdl/dtq_exec.sv
// Back end: slot store, overdue scan, firing and result register.
module dtq_exec
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int MAX_FIRES  = MAX_FIRES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_word  i_word,
    input  logic      i_bad_slot,
    output logic      o_take,
    output logic      o_empty,
    output t_out_word o_word,
    input  logic      i_pop
);
    localparam int SW = $clog2(NUM_TIMERS);
    localparam int LIM = (MAX_FIRES < RESULT_LIMIT) ? MAX_FIRES : RESULT_LIMIT;
    localparam int CW = $clog2(LIM + 1);

    t_exec_state r_state, n_state;
    logic [NUM_TIMERS-1:0] r_active, r_rep;
    logic [31:0] r_dl_s [NUM_TIMERS];
    logic [19:0] r_dl_us [NUM_TIMERS];
    logic [31:0] r_rl_s [NUM_TIMERS];
    logic [19:0] r_rl_us [NUM_TIMERS];
    logic [31:0] r_cur_s;
    logic [19:0] r_cur_us;
    logic [SW:0] r_idx;
    logic        r_found;
    logic [SW-1:0] r_best;
    logic [SW-1:0] r_pend;
    logic [CW-1:0] r_cnt;
    logic        r_ovalid;
    t_out_word   r_out;
    t_out_word   n_out;

    logic [SW-1:0] idx;
    logic [SW-1:0] slot;
    logic          cand;
    logic          stall;
    logic          scan_end;
    logic          cap_hit;
    logic          load;

    assign idx      = r_idx[SW-1:0];
    assign slot     = SW'(i_word.timer_slot);
    assign stall    = r_ovalid && !i_pop;
    assign scan_end = (r_idx == (SW+1)'(NUM_TIMERS - 1));
    assign cap_hit  = (r_cnt == CW'(LIM));
    assign cand     = r_active[idx] &&
                      !time_lt(r_cur_s, r_cur_us, r_dl_s[idx], r_dl_us[idx]) &&
                      (!r_found || time_lt(r_dl_s[idx], r_dl_us[idx],
                                           r_dl_s[r_best], r_dl_us[r_best]));

    // A fire word waits in r_pend until the following scan, or reaching the cap, tells whether it is last.
    always_comb begin
        n_state = r_state;
        o_take  = 1'b0;
        load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && !stall) begin
                    o_take = 1'b1;
                    if (t_op'(i_word.op) == OP_TICK) begin
                        n_state = ST_SCAN;
                    end else begin
                        load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    if (r_cnt != '0) begin
                        n_state = ST_EMIT;
                    end else if (r_found || cand) begin
                        n_state = ST_FIRE;
                    end else begin
                        n_state = ST_NOFIRE;
                    end
                end
            end
            ST_FIRE: n_state = (r_cnt == CW'(LIM - 1)) ? ST_EMIT : ST_SCAN;
            ST_EMIT: begin
                if (!stall) begin
                    load    = 1'b1;
                    n_state = (r_found && !cap_hit) ? ST_FIRE : ST_IDLE;
                end
            end
            ST_NOFIRE: begin
                if (!stall) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out      = '0;
        n_out.last = 1'b1;
        case (r_state)
            ST_IDLE: begin
                case (t_op'(i_word.op))
                    OP_ARM: begin
                        n_out.status = i_bad_slot;
                        if (!i_bad_slot) begin
                            n_out.old_interval_sec  = r_rl_s[slot];
                            n_out.old_interval_usec = r_rl_us[slot];
                            if (r_active[slot] && time_lt(r_cur_s, r_cur_us,
                                    r_dl_s[slot], r_dl_us[slot])) begin
                                if (r_dl_us[slot] >= r_cur_us) begin
                                    n_out.old_remaining_usec = r_dl_us[slot] - r_cur_us;
                                    n_out.old_remaining_sec  = r_dl_s[slot] - r_cur_s;
                                end else begin
                                    n_out.old_remaining_usec = 20'(
                                        {1'b0, r_dl_us[slot]} + USEC_PER_SEC
                                        - {1'b0, r_cur_us});
                                    n_out.old_remaining_sec =
                                        r_dl_s[slot] - r_cur_s - 32'd1;
                                end
                            end
                        end
                    end
                    OP_DISARM: n_out.status = i_bad_slot || !r_active[slot];
                    default: ;
                endcase
            end
            ST_EMIT: begin
                n_out.fired        = 1'b1;
                n_out.expired_slot = 4'(r_pend);
                // last when the cap is hit or the rescan found nothing
                n_out.last         = cap_hit || !r_found;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_rep    <= '0;
            r_cur_s  <= '0;
            r_cur_us <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_cnt    <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_rl_s[i]  <= '0;
                r_rl_us[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_take) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_cnt   <= '0;
                        case (t_op'(i_word.op))
                            OP_TICK: begin
                                r_cur_s  <= i_word.now_sec;
                                r_cur_us <= i_word.now_usec;
                            end
                            OP_ARM: begin
                                if (!i_bad_slot) begin
                                    r_rl_s[slot]  <= i_word.interval_sec;
                                    r_rl_us[slot] <= i_word.interval_usec;
                                    r_rep[slot]   <= i_word.repeat_mode;
                                    {r_dl_s[slot], r_dl_us[slot]} <= time_add(r_cur_s,
                                        r_cur_us, i_word.value_sec, i_word.value_usec);
                                    r_active[slot] <= 1'b1;
                                end
                            end
                            OP_DISARM: begin
                                if (!i_bad_slot) begin
                                    r_active[slot] <= 1'b0;
                                    r_rep[slot]    <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (cand) begin
                        r_found <= 1'b1;
                        r_best  <= idx;
                    end
                    r_idx <= r_idx + (SW+1)'(1);
                end
                ST_FIRE: begin
                    if (r_rep[r_best]) begin
                        {r_dl_s[r_best], r_dl_us[r_best]} <= time_add(r_dl_s[r_best],
                            r_dl_us[r_best], r_rl_s[r_best], r_rl_us[r_best]);
                    end else begin
                        r_active[r_best] <= 1'b0;
                    end
                    r_pend  <= r_best;
                    r_cnt   <= r_cnt + CW'(1);
                    r_idx   <= '0;
                    r_found <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_empty = !r_ovalid;
    assign o_word  = r_out;

`ifndef SYNTHESIS
    a_nofire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_word.fired) |-> o_word.last) else $error("non-fire word not last");
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_word.fired) |-> (o_word.status == 1'b0)) else $error("fire status");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(LIM)) else $error("fire count over cap");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_pop) |=> (r_ovalid && $stable(r_out)))
        else $error("waiting word changed");
`endif
endmodule

// File: hdl/deadline_timer_queue_top.sv
// Top level of the deadline timer queue.
// A bank of timer slots driven by tick, arm and disarm words. A front register
// accepts a word (full is high while it holds one) and frees itself when the
// back end takes the word; the back end takes a word only while it is idle and
// no result word waits unread. A tick scans the slots one per cycle and rescans
// after every firing that does not reach the cap, to find the next overdue slot
// and to decide whether the previous fire word is the last one. A result word
// that waits unread holds the back end. Results are read from a queue-style port.
module deadline_timer_queue_top
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS         = NUM_TIMERS_DEF,
    parameter int MAX_FIRES_PER_TICK = MAX_FIRES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_in,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_out
);
    logic     fr_valid, fr_bad, take;
    t_in_word fr_word;

    dtq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_word(i_in),
        .o_valid(fr_valid), .o_word(fr_word), .o_bad_slot(fr_bad), .i_take(take)
    );

    dtq_exec #(.NUM_TIMERS(NUM_TIMERS), .MAX_FIRES(MAX_FIRES_PER_TICK)) u_exec (
        .i_clk, .i_rst_n, .i_valid(fr_valid), .i_word(fr_word), .i_bad_slot(fr_bad),
        .o_take(take), .o_empty(empty), .o_word(o_out), .i_pop(pop)
    );
endmodule

// File: tb/sv/deadline_timer_queue_top_test.sv
// Self-checking testbench for the deadline timer queue: directed table plus random words.
module deadline_timer_queue_top_test;
    import dtq_pkg::*;

    localparam int N_SLOTS   = 16;
    localparam int FIRE_CAP  = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_WORDS = 347;
    localparam int DRAIN_CYCLES = 400;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_word  i_in = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_word o_out;

    deadline_timer_queue_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_in    (i_in),
        .empty   (empty),
        .pop     (pop),
        .o_out   (o_out)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: a private copy of the slot bank.
    logic        tm_active [N_SLOTS];
    logic        tm_repeat [N_SLOTS];
    logic [31:0] tm_dl_s   [N_SLOTS];
    logic [19:0] tm_dl_us  [N_SLOTS];
    logic [31:0] tm_rl_s   [N_SLOTS];
    logic [19:0] tm_rl_us  [N_SLOTS];
    logic [31:0] now_s;
    logic [19:0] now_us;

    t_out_word pending_words[$];
    int        errors = 0;
    int        idle_cycles = 0;

    // Directed table: a word, plus a typed-in expected result where it is obvious.
    typedef struct {
        t_in_word  w;
        logic      has_exp;
        t_out_word exp;
    } t_row;
    t_row table_rows[$];

    function automatic logic [19:0] sat_us(logic [19:0] v);
        return (v > 20'd999999) ? 20'd999999 : v;
    endfunction

    function automatic logic earlier(logic [31:0] as, logic [19:0] aus,
                                     logic [31:0] bs, logic [19:0] bus);
        return (as < bs) || (as == bs && aus < bus);
    endfunction

    function automatic logic [51:0] add_times(logic [31:0] as, logic [19:0] aus,
                                              logic [31:0] bs, logic [19:0] bus);
        logic [32:0] s;
        logic [20:0] us;
        s  = {1'b0, as} + {1'b0, bs};
        us = {1'b0, aus} + {1'b0, bus};
        if (us >= 21'd1000000) begin
            us = us - 21'd1000000;
            s  = s + 33'd1;
        end
        if (s[32]) return {32'hFFFF_FFFF, 20'd999999};
        return {s[31:0], us[19:0]};
    endfunction

    task automatic clear_timer_bank();
        for (int i = 0; i < N_SLOTS; i++) begin
            tm_active[i] = 0; tm_repeat[i] = 0; tm_dl_s[i] = 0; tm_dl_us[i] = 0;
            tm_rl_s[i] = 0; tm_rl_us[i] = 0;
        end
        now_s = 0; now_us = 0;
    endtask

    // Advance the bank by one accepted word and queue the words it must emit.
    task automatic predict_timer_words(input t_in_word w);
        t_out_word r;
        logic [51:0] t;
        int n, best;
        n = 0;
        r = '0;
        case (t_op'(w.op))
            OP_TICK: begin
                now_s = w.now_sec; now_us = sat_us(w.now_usec);
                while (n < FIRE_CAP) begin
                    best = -1;
                    for (int i = 0; i < N_SLOTS; i++) begin
                        if (tm_active[i] && !earlier(now_s, now_us, tm_dl_s[i], tm_dl_us[i]))
                            if (best < 0 || earlier(tm_dl_s[i], tm_dl_us[i],
                                                    tm_dl_s[best], tm_dl_us[best]))
                                best = i;
                    end
                    if (best < 0) break;
                    r = '0; r.fired = 1; r.expired_slot = best[3:0];
                    pending_words.push_back(r);
                    n++;
                    if (tm_repeat[best]) begin
                        t = add_times(tm_dl_s[best], tm_dl_us[best],
                                      tm_rl_s[best], tm_rl_us[best]);
                        tm_dl_s[best] = t[51:20]; tm_dl_us[best] = t[19:0];
                    end else begin
                        tm_active[best] = 0;
                    end
                end
                if (n == 0) pending_words.push_back('0);
            end
            OP_ARM: begin
                logic [31:0] is;
                logic [19:0] ius;
                is = w.interval_sec; ius = sat_us(w.interval_usec);
                r.old_interval_sec = tm_rl_s[w.timer_slot];
                r.old_interval_usec = tm_rl_us[w.timer_slot];
                if (tm_active[w.timer_slot] && earlier(now_s, now_us,
                        tm_dl_s[w.timer_slot], tm_dl_us[w.timer_slot])) begin
                    if (tm_dl_us[w.timer_slot] >= now_us) begin
                        r.old_remaining_usec = tm_dl_us[w.timer_slot] - now_us;
                        r.old_remaining_sec = tm_dl_s[w.timer_slot] - now_s;
                    end else begin
                        r.old_remaining_usec = tm_dl_us[w.timer_slot] + 20'd1000000 - now_us;
                        r.old_remaining_sec = tm_dl_s[w.timer_slot] - now_s - 32'd1;
                    end
                end
                tm_rl_s[w.timer_slot] = is; tm_rl_us[w.timer_slot] = ius;
                tm_repeat[w.timer_slot] = w.repeat_mode && (is != 0 || ius != 0);
                t = add_times(now_s, now_us, w.value_sec, sat_us(w.value_usec));
                tm_dl_s[w.timer_slot] = t[51:20]; tm_dl_us[w.timer_slot] = t[19:0];
                tm_active[w.timer_slot] = 1;
                pending_words.push_back(r);
            end
            OP_DISARM: begin
                r.status = !tm_active[w.timer_slot];
                tm_active[w.timer_slot] = 0; tm_repeat[w.timer_slot] = 0;
                pending_words.push_back(r);
            end
            default: pending_words.push_back(r);
        endcase
        // Mark the final word of this input.
        r = pending_words.pop_back();
        r.last = 1;
        pending_words.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input t_out_word got,
                                   input t_out_word want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // Receiver: stall on a pattern of its own, compare each popped word.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", o_out, '0);
            end else begin
                t_out_word want;
                want = pending_words.pop_front();
                if (o_out !== want) report_mismatch("field", o_out, want);
            end
        end
        // Vary the stall pattern: none, light, heavy, moderate.
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ($urandom_range(0, 7) < 5);
        endcase
    end

    // Watchdog: count cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Hold the word on the port until it is taken; then check the table expectation.
    task automatic send_word(input t_in_word w, input logic has_exp, input t_out_word exp);
        int first_idx;
        push <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (full);
        first_idx = pending_words.size();
        predict_timer_words(w);
        if (has_exp && pending_words[first_idx] !== exp)
            report_mismatch("table row", pending_words[first_idx], exp);
    endtask

    task automatic sender_gap();
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(t_op op, logic [3:0] slot, logic [31:0] s,
                                           logic [19:0] us, logic [31:0] is,
                                           logic [19:0] ius, logic rep);
        t_in_word w;
        w = '0;
        w.op = op; w.timer_slot = slot;
        if (op == OP_TICK) begin
            w.now_sec = s; w.now_usec = us;
        end else begin
            w.value_sec = s; w.value_usec = us;
        end
        w.interval_sec = is; w.interval_usec = ius; w.repeat_mode = rep;
        return w;
    endfunction

    task automatic add_row(input t_in_word w, input logic has, input t_out_word e);
        t_row row;
        row.w = w; row.has_exp = has; row.exp = e;
        table_rows.push_back(row);
    endtask

    task automatic build_table();
        t_out_word e;
        // A tick after reset fires nothing.
        e = '0; e.last = 1;
        add_row(make_word(OP_TICK, 0, 0, 0, 0, 0, 0), 1, e);
        // Disarm of an inactive slot reports status.
        e.status = 1;
        add_row(make_word(OP_DISARM, 4'd15, 0, 0, 0, 0, 0), 1, e);
        // Arm of an inactive slot: zero remaining, stored interval zero.
        e = '0; e.last = 1;
        add_row(make_word(OP_ARM, 0, 0, 0, 0, 0, 1), 1, e);
        add_row(make_word(OP_ARM, 4'd15, 32'hFFFF_FFFF, 20'hFFFFF,
                          32'hFFFF_FFFF, 20'hFFFFF, 1), 1, e);
        add_row(make_word(OP_ARM, 3, 5, 999999, 1, 1, 1), 1, e);
        add_row(make_word(OP_ARM, 4, 5, 999999, 0, 0, 1), 1, e);
        add_row(make_word(OP_ARM, 5, 2, 500000, 0, 300000, 1), 1, e);
        add_row(make_word(OP_ARM, 6, 2, 500000, 0, 0, 0), 1, e);
        // Zero delay fires on the next tick; ties go to the lower slot.
        add_row(make_word(OP_TICK, 0, 0, 0, 0, 0, 0), 0, e);
        // Re-arm active slot with remaining time and borrow.
        add_row(make_word(OP_TICK, 0, 1, 700000, 0, 0, 0), 0, e);
        add_row(make_word(OP_ARM, 3, 1, 0, 2, 0, 0), 0, e);
        add_row(make_word(OP_ARM, 5, 0, 0, 1, 0, 1), 0, e);
        // Repeating slot fires many times in one tick, up to the cap.
        add_row(make_word(OP_ARM, 7, 0, 1, 0, 1, 1), 0, e);
        add_row(make_word(OP_TICK, 0, 30, 20'hFFFFF, 0, 0, 0), 0, e);
        add_row(make_word(OP_TICK, 0, 30, 999999, 0, 0, 0), 0, e);
        add_row(make_word(OP_DISARM, 7, 0, 0, 0, 0, 0), 0, e);
        add_row(make_word(OP_DISARM, 7, 0, 0, 0, 0, 0), 0, e);
        // Unknown op changes nothing.
        add_row(make_word(OP_NONE, 4'd9, 32'hFFFF_FFFF, 20'hFFFFF,
                          32'hFFFF_FFFF, 20'hFFFFF, 1), 0, e);
        // Past deadline on re-arm gives zero remaining; saturation at the top.
        add_row(make_word(OP_TICK, 0, 32'hFFFF_FFF0, 0, 0, 0, 0), 0, e);
        add_row(make_word(OP_ARM, 8, 32'h20, 0, 32'hFFFF_FFFF, 999999, 1), 0, e);
        add_row(make_word(OP_TICK, 0, 32'hFFFF_FFFF, 999999, 0, 0, 0), 0, e);
        add_row(make_word(OP_ARM, 15, 0, 0, 0, 0, 0), 0, e);
        add_row(make_word(OP_TICK, 0, 32'hFFFF_FFFF, 999999, 0, 0, 0), 0, e);
    endtask

    // Random word, mostly well-formed: arms near now, ticks moving forward.
    task automatic random_word(output t_in_word w);
        int k;
        k = $urandom_range(0, 99);
        w = '0;
        w.timer_slot = 4'($urandom_range(0, 15));
        w.repeat_mode = 1'($urandom_range(0, 1));
        if (k < 40) begin
            w.op = OP_TICK;
            if ($urandom_range(0, 19) == 0) begin
                w.now_sec = $urandom(); w.now_usec = 20'($urandom());
            end else begin
                logic [51:0] t;
                t = add_times(now_s, now_us, 32'($urandom_range(0, 3)),
                              20'($urandom_range(0, 999999)));
                w.now_sec = t[51:20]; w.now_usec = t[19:0];
            end
        end else if (k < 80) begin
            w.op = OP_ARM;
            w.value_sec = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4);
            w.value_usec = ($urandom_range(0, 9) == 0) ? 20'($urandom())
                                                       : 20'($urandom_range(0, 999999));
            w.interval_sec = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 2);
            w.interval_usec = ($urandom_range(0, 9) == 0) ? 20'($urandom())
                                                          : 20'($urandom_range(0, 999999));
            if ($urandom_range(0, 7) == 0) begin
                w.interval_sec = 0; w.interval_usec = 0;
            end
        end else if (k < 95) begin
            w.op = OP_DISARM;
        end else begin
            w.op = OP_NONE;
            w.now_sec = $urandom(); w.now_usec = 20'($urandom());
            w.value_sec = $urandom(); w.value_usec = 20'($urandom());
            w.interval_sec = $urandom(); w.interval_usec = 20'($urandom());
        end
    endtask

    initial begin
        t_in_word w;
        int burst;
        int wait_cycles;
        clear_timer_bank();
        build_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table; typed-in rows must agree with the predictor too.
        foreach (table_rows[i]) begin
            send_word(table_rows[i].w, table_rows[i].has_exp, table_rows[i].exp);
            if ($urandom_range(0, 2) == 0) sender_gap();
        end

        // Random bursts with random gaps between them.
        burst = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (burst == 0) begin
                sender_gap();
                burst = $urandom_range(1, 20);
            end
            random_word(w);
            send_word(w, 1'b0, '0);
            burst--;
        end
        push <= 1'b0;

        // Drain: wait for all expected words, then let the block settle.
        wait_cycles = 0;
        while (pending_words.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: deadline_timer_queue_top.f
hdl/dtq_pkg.sv
hdl/dtq_front.sv
hdl/dtq_exec.sv
hdl/deadline_timer_queue_top.sv
tb/sv/deadline_timer_queue_top_test.sv
